// ===== hw/rtl/istft_overlap_add_normalizer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the overlap-add normalizer checks.
// ----------------------------------------------------------------------------
`ifndef ISTFT_OVERLAP_ADD_NORMALIZER_MACROS_SVH
`define ISTFT_OVERLAP_ADD_NORMALIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OLA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("overlap-add check failed");

// Next-cycle implication, disabled during reset.
`define OLA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("overlap-add check failed");

`endif

// ===== hw/rtl/istft_ola_pkg.sv =====
// ----------------------------------------------------------------------------
// istft_ola_pkg
// Types, codes and sizes shared by the overlap-add normalizer modules.
// ----------------------------------------------------------------------------
package istft_ola_pkg;

    localparam int MAX_FFT   = 4096;
    localparam int FFT_MIN   = 16;
    localparam int ADDR_W    = 12;
    localparam int CNT_W     = 13;
    localparam int K_W       = 16;
    localparam int FP_W      = 32;
    localparam int EM_W      = 24;
    localparam int LEN_W     = 29;
    localparam int SUM_W     = 48;
    localparam int WT_W      = 24;
    localparam int COEF_W    = 17;
    localparam int EPS_W     = 16;
    localparam int SMP_W     = 32;
    localparam int MUL_W     = 50;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int DIV_N_W   = 64;
    localparam int DIV_D_W   = 24;
    localparam int DIV_CNT_W = 7;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_PUSH  = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_MANY = 2'd1;
    localparam logic [1:0] ST_EARLY    = 2'd2;
    localparam logic [1:0] ST_DONE     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FFT_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOP_SIZE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTERED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LENGTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON     = 3'd5;

    localparam logic [3:0] OP_NOP        = 4'd0;
    localparam logic [3:0] OP_CAPTURE    = 4'd1;
    localparam logic [3:0] OP_LOAD       = 4'd2;
    localparam logic [3:0] OP_MOD_FIN    = 4'd3;
    localparam logic [3:0] OP_MOD_ADD    = 4'd4;
    localparam logic [3:0] OP_RING_RD    = 4'd5;
    localparam logic [3:0] OP_FIN_LATCH  = 4'd6;
    localparam logic [3:0] OP_BYPASS     = 4'd7;
    localparam logic [3:0] OP_NORM_START = 4'd8;
    localparam logic [3:0] OP_NORM_DONE  = 4'd9;
    localparam logic [3:0] OP_ADD_WRITE  = 4'd10;
    localparam logic [3:0] OP_EMIT       = 4'd11;
    localparam logic [3:0] OP_CLEAR      = 4'd12;

    typedef struct packed {
        logic [1:0]              func;
        logic [ADDR_W-1:0]       index;
        logic signed [SMP_W-1:0] sample;
        logic [COEF_W-1:0]       synth_coef;
        logic [COEF_W-1:0]       product_coef;
    } t_in_item;

    typedef struct packed {
        logic signed [SMP_W-1:0] value;
        logic                    last;
        logic [1:0]              status;
    } t_out_item;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] status;
        logic       zero;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       clear_done;
        logic       div_busy;
        logic       frames_full;
        logic       fin_due;
        logic       frame_open;
        logic       out_done;
        logic       tail_left;
        logic       in_window;
        logic       below_eps;
        logic       out_free;
    } t_dp_sts;

endpackage

// ===== hw/rtl/istft_ola_div.sv =====
// ----------------------------------------------------------------------------
// istft_ola_div
// Restoring divider, one quotient bit per cycle: 32 steps for the ring
// modulo, 64 steps for window-sum normalization.
// ----------------------------------------------------------------------------
module istft_ola_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_norm,
    input  logic [istft_ola_pkg::DIV_N_W-1:0]  i_dividend,
    input  logic [istft_ola_pkg::DIV_D_W-1:0]  i_divisor,
    output logic                               o_busy,
    output logic [istft_ola_pkg::DIV_N_W-1:0]  o_quot,
    output logic [istft_ola_pkg::DIV_D_W-1:0]  o_rem
);
    import istft_ola_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_N_W-1:0]   r_q;
    logic [DIV_D_W-1:0]   r_r;
    logic [DIV_D_W-1:0]   r_d;
    logic [DIV_D_W:0]     w_trial;
    logic [DIV_D_W:0]     w_diff;
    logic                 w_ge;

    always_comb begin
        w_trial = {r_r, r_q[DIV_N_W-1]};
        w_ge    = w_trial >= {1'b0, r_d};
        w_diff  = w_trial - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_norm ? DIV_CNT_W'(DIV_N_W) : DIV_CNT_W'(DIV_N_W / 2);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_norm ? i_dividend
                          : {i_dividend[DIV_N_W/2-1:0], {(DIV_N_W/2){1'b0}}};
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q <= {r_q[DIV_N_W-2:0], w_ge};
            r_r <= w_ge ? w_diff[DIV_D_W-1:0] : w_trial[DIV_D_W-1:0];
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

// ===== hw/rtl/istft_ola_dp.sv =====
// ----------------------------------------------------------------------------
// istft_ola_dp
// Datapath: configuration, window tables, overlap-add ring, counters,
// shared divider and the output word register.
// ----------------------------------------------------------------------------
`include "istft_overlap_add_normalizer_macros.svh"

module istft_ola_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [istft_ola_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [istft_ola_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  istft_ola_pkg::t_in_item              i_in,
    input  istft_ola_pkg::t_dp_cmd               i_cmd,
    input  logic                                 i_stall,
    output istft_ola_pkg::t_dp_sts               o_sts,
    output logic                                 o_valid,
    output istft_ola_pkg::t_out_item             o_out
);
    import istft_ola_pkg::*;

    // Configuration.
    logic [CNT_W-1:0]  r_cfg_fft;
    logic [CNT_W-1:0]  r_cfg_hop;
    logic [K_W-1:0]    r_fc;
    logic              r_centered;
    logic [EM_W-1:0]   r_ol;
    logic [EPS_W-1:0]  r_eps;

    // Derived geometry.
    logic [CNT_W-1:0]  w_f;
    logic [CNT_W-1:0]  w_h;
    logic [CNT_W-1:0]  r_f;
    logic [CNT_W-1:0]  r_h;
    logic [LEN_W-1:0]  r_kh;
    logic [LEN_W-1:0]  r_fl;
    logic [ADDR_W-1:0] r_ts;
    logic [LEN_W-1:0]  r_te;
    logic [K_W-1:0]    w_fcm1;
    logic [LEN_W-1:0]  w_ts_ext;
    logic [LEN_W-1:0]  w_avail;

    // Counters.
    logic [K_W-1:0]    r_k;
    logic [ADDR_W-1:0] r_i;
    logic [FP_W-1:0]   r_fp;
    logic [EM_W-1:0]   r_em;
    logic [CNT_W-1:0]  r_clr;
    logic [CNT_W-1:0]  w_i_next;
    logic [EM_W-1:0]   w_em_next;

    // Item.
    logic [1:0]              r_func;
    logic [ADDR_W-1:0]       r_index;
    logic signed [SMP_W-1:0] r_sample;
    logic [COEF_W-1:0]       r_synth;
    logic [COEF_W-1:0]       r_prodc;

    // Tables and ring.
    logic [COEF_W-1:0] r_synth_mem [MAX_FFT];
    logic [COEF_W-1:0] r_prod_mem  [MAX_FFT];
    logic [SUM_W-1:0]  r_sum_mem   [MAX_FFT];
    logic [WT_W-1:0]   r_wt_mem    [MAX_FFT];
    logic [COEF_W-1:0] r_sc;
    logic [COEF_W-1:0] r_pc;
    logic [SUM_W-1:0]  r_rd_sum;
    logic [WT_W-1:0]   r_rd_wt;
    logic [ADDR_W-1:0] r_slot;

    // Finalize and accumulate.
    logic [SUM_W-1:0]        r_sum;
    logic [SUM_W-1:0]        r_mag;
    logic                    r_neg;
    logic [WT_W-1:0]         r_wt;
    logic                    r_below;
    logic                    r_in_win;
    logic signed [SMP_W-1:0] r_val;
    logic signed [MUL_W-1:0] r_mul;
    logic signed [MUL_W-1:0] w_t;
    logic signed [MUL_W-1:0] w_c;
    logic [SUM_W:0]          w_acc;
    logic [SUM_W-1:0]        w_acc_sat;
    logic [WT_W:0]           w_wt;
    logic [WT_W-1:0]         w_wt_sat;
    logic [SUM_W-1:0]        w_rd_mag;

    // Ring write port.
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [SUM_W-1:0]  w_wsum;
    logic [WT_W-1:0]   w_wwt;

    // Divider.
    logic               div_start;
    logic               div_norm;
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    logic               div_busy;
    logic [DIV_N_W-1:0] div_quot;
    logic [DIV_D_W-1:0] div_rem;

    // Output.
    logic      r_out_valid;
    t_out_item r_out;
    logic      out_free;
    logic      emit_fire;
    logic      clear_done;

    always_comb begin
        if (r_cfg_fft < CNT_W'(FFT_MIN)) begin
            w_f = CNT_W'(FFT_MIN);
        end else if (r_cfg_fft > CNT_W'(MAX_FFT)) begin
            w_f = CNT_W'(MAX_FFT);
        end else begin
            w_f = r_cfg_fft;
        end
        if (r_cfg_hop == '0) begin
            w_h = CNT_W'(1);
        end else if (r_cfg_hop > w_f) begin
            w_h = w_f;
        end else begin
            w_h = r_cfg_hop;
        end
        w_fcm1   = r_fc - 1'b1;
        w_ts_ext = LEN_W'(r_ts);
        if (w_ts_ext < r_fl) begin
            w_avail = r_fl - w_ts_ext;
            if (w_avail > LEN_W'(r_ol)) begin
                w_avail = LEN_W'(r_ol);
            end
        end else begin
            w_avail = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f  <= w_f;
        r_h  <= w_h;
        r_kh <= LEN_W'(r_k) * LEN_W'(r_h);
        r_fl <= (r_fc == '0) ? '0 : LEN_W'(w_fcm1) * LEN_W'(r_h) + LEN_W'(r_f);
        r_ts <= r_centered ? r_f[CNT_W-1:1] : '0;
        r_te <= w_ts_ext + w_avail;
    end

    assign out_free   = !r_out_valid || !i_stall;
    assign emit_fire  = (i_cmd.op == OP_EMIT) && out_free;
    assign clear_done = r_clr == CNT_W'(MAX_FFT);
    assign w_i_next   = CNT_W'(r_i) + 1'b1;
    assign w_em_next  = r_em + 1'b1;

    always_comb begin
        div_start    = (i_cmd.op == OP_MOD_FIN) || (i_cmd.op == OP_MOD_ADD)
                       || (i_cmd.op == OP_NORM_START);
        div_norm     = i_cmd.op == OP_NORM_START;
        div_dividend = {{(DIV_N_W-FP_W){1'b0}}, r_fp};
        div_divisor  = DIV_D_W'(r_f);
        if (i_cmd.op == OP_MOD_ADD) begin
            div_dividend = DIV_N_W'(r_kh) + DIV_N_W'(r_i);
        end else if (i_cmd.op == OP_NORM_START) begin
            div_dividend = {r_mag, 16'd0} + DIV_N_W'(r_wt[WT_W-1:1]);
            div_divisor  = r_wt;
        end
    end

    istft_ola_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_norm     (div_norm),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        w_t   = r_mul + MUL_W'(32768);
        w_c   = w_t >>> 16;
        w_acc = {r_rd_sum[SUM_W-1], r_rd_sum} + w_c[SUM_W:0];
        if (w_acc[SUM_W] != w_acc[SUM_W-1]) begin
            w_acc_sat = w_acc[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                     : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            w_acc_sat = w_acc[SUM_W-1:0];
        end
        w_wt     = {1'b0, r_rd_wt} + (WT_W+1)'(r_pc);
        w_wt_sat = w_wt[WT_W] ? {WT_W{1'b1}} : w_wt[WT_W-1:0];
        w_rd_mag = r_rd_sum[SUM_W-1] ? (~r_rd_sum + 1'b1) : r_rd_sum;

        w_we    = (i_cmd.op == OP_CLEAR) || (i_cmd.op == OP_FIN_LATCH)
                  || (i_cmd.op == OP_ADD_WRITE);
        w_waddr = (i_cmd.op == OP_CLEAR) ? r_clr[ADDR_W-1:0] : r_slot;
        w_wsum  = (i_cmd.op == OP_ADD_WRITE) ? w_acc_sat : '0;
        w_wwt   = (i_cmd.op == OP_ADD_WRITE) ? w_wt_sat : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_sum_mem[w_waddr] <= w_wsum;
            r_wt_mem[w_waddr]  <= w_wwt;
        end
        if (i_cmd.op == OP_RING_RD) begin
            r_rd_sum <= r_sum_mem[div_rem[ADDR_W-1:0]];
            r_rd_wt  <= r_wt_mem[div_rem[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_synth_mem[r_index] <= r_synth;
            r_prod_mem[r_index]  <= r_prodc;
        end
        if (i_cmd.op == OP_MOD_ADD) begin
            r_sc <= r_synth_mem[r_i];
            r_pc <= r_prod_mem[r_i];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_CAPTURE) begin
            r_func   <= i_in.func;
            r_index  <= i_in.index;
            r_sample <= i_in.sample;
            r_synth  <= i_in.synth_coef;
            r_prodc  <= i_in.product_coef;
        end
        if (i_cmd.op == OP_RING_RD) begin
            r_slot <= div_rem[ADDR_W-1:0];
            r_mul  <= r_sample * $signed({1'b0, r_sc});
        end
        if (i_cmd.op == OP_FIN_LATCH) begin
            r_sum    <= r_rd_sum;
            r_mag    <= w_rd_mag;
            r_neg    <= r_rd_sum[SUM_W-1];
            r_wt     <= r_rd_wt;
            r_below  <= r_rd_wt <= WT_W'(r_eps);
            r_in_win <= (r_fp >= FP_W'(r_ts)) && (r_fp < FP_W'(r_te));
        end
        if (i_cmd.op == OP_BYPASS) begin
            if ($signed(r_sum) > $signed(SUM_W'(32'h7FFF_FFFF))) begin
                r_val <= 32'sh7FFF_FFFF;
            end else if ($signed(r_sum) < -$signed(SUM_W'(33'h0_8000_0000))) begin
                r_val <= 32'sh8000_0000;
            end else begin
                r_val <= $signed(r_sum[SMP_W-1:0]);
            end
        end
        if (i_cmd.op == OP_NORM_DONE) begin
            if (r_neg) begin
                r_val <= (div_quot > DIV_N_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                         : $signed(-div_quot[SMP_W-1:0]);
            end else begin
                r_val <= (div_quot > DIV_N_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                         : $signed(div_quot[SMP_W-1:0]);
            end
        end
        if (emit_fire) begin
            r_out.status <= i_cmd.status;
            if (i_cmd.status == ST_OK) begin
                r_out.value <= i_cmd.zero ? 32'sd0 : r_val;
                r_out.last  <= w_em_next == r_ol;
            end else begin
                r_out.value <= 32'sd0;
                r_out.last  <= 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_fft   <= CNT_W'(2048);
            r_cfg_hop   <= CNT_W'(512);
            r_fc        <= K_W'(1);
            r_centered  <= 1'b1;
            r_ol        <= EM_W'(1);
            r_eps       <= EPS_W'(1);
            r_k         <= '0;
            r_i         <= '0;
            r_fp        <= '0;
            r_em        <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FFT_SIZE:    r_cfg_fft  <= i_cfg_data[CNT_W-1:0];
                    CFG_HOP_SIZE:    r_cfg_hop  <= i_cfg_data[CNT_W-1:0];
                    CFG_FRAME_COUNT: r_fc       <= i_cfg_data[K_W-1:0];
                    CFG_CENTERED:    r_centered <= i_cfg_data[0];
                    CFG_OUT_LENGTH:  r_ol       <= i_cfg_data[EM_W-1:0];
                    CFG_EPSILON:     r_eps      <= i_cfg_data[EPS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.op == OP_FIN_LATCH) begin
                r_fp <= r_fp + 1'b1;
            end
            if (i_cmd.op == OP_ADD_WRITE) begin
                if (w_i_next >= r_f) begin
                    r_i <= '0;
                    r_k <= r_k + 1'b1;
                end else begin
                    r_i <= w_i_next[ADDR_W-1:0];
                end
            end
            if (emit_fire) begin
                r_out_valid <= 1'b1;
                if (i_cmd.status == ST_OK) begin
                    r_em <= w_em_next;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.func        = r_func;
        o_sts.clear_done  = clear_done;
        o_sts.div_busy    = div_busy;
        o_sts.frames_full = r_k >= r_fc;
        o_sts.fin_due     = (r_k != '0) && (r_fp < FP_W'(r_kh));
        o_sts.frame_open  = (r_k < r_fc) || (r_i != '0);
        o_sts.out_done    = r_em >= r_ol;
        o_sts.tail_left   = r_fp < FP_W'(r_fl);
        o_sts.in_window   = r_in_win;
        o_sts.below_eps   = r_below;
        o_sts.out_free    = out_free;
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    `OLA_ASSERT_IMP(a_div_idle_on_start, i_clk, i_rst_n, div_start, !div_busy)
    `OLA_ASSERT_NXT(a_err_word_zero, i_clk, i_rst_n, emit_fire && (i_cmd.status != ST_OK), r_out_valid && (r_out.value == 32'sd0) && !r_out.last)
    `OLA_ASSERT_NXT(a_fp_only_on_finalize, i_clk, i_rst_n, i_cmd.op != OP_FIN_LATCH, $stable(r_fp))
    `OLA_ASSERT_IMP(a_no_word_during_clear, i_clk, i_rst_n, i_cmd.op == OP_CAPTURE, clear_done)

endmodule

// ===== hw/rtl/istft_ola_ctrl.sv =====
// ----------------------------------------------------------------------------
// istft_ola_ctrl
// Sequencer for load, push and flush words and the ring clearing pass.
// ----------------------------------------------------------------------------
module istft_ola_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  istft_ola_pkg::t_dp_sts  i_sts,
    output istft_ola_pkg::t_dp_cmd  o_cmd,
    output logic                    o_ready
);
    import istft_ola_pkg::*;

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_PREP      = 4'd2;
    localparam logic [3:0] S_DECODE    = 4'd3;
    localparam logic [3:0] S_FIN_DIV   = 4'd4;
    localparam logic [3:0] S_FIN_WAIT  = 4'd5;
    localparam logic [3:0] S_FIN_RD    = 4'd6;
    localparam logic [3:0] S_FIN_LATCH = 4'd7;
    localparam logic [3:0] S_FIN_NORM  = 4'd8;
    localparam logic [3:0] S_NORM_WAIT = 4'd9;
    localparam logic [3:0] S_FIN_END   = 4'd10;
    localparam logic [3:0] S_EMIT      = 4'd11;
    localparam logic [3:0] S_ADD_DIV   = 4'd12;
    localparam logic [3:0] S_ADD_WAIT  = 4'd13;
    localparam logic [3:0] S_ADD_RD    = 4'd14;
    localparam logic [3:0] S_ADD_WR    = 4'd15;

    logic [3:0] r_state, n_state;
    logic [1:0] r_prep, n_prep;
    logic [1:0] r_status, n_status;
    logic       r_zero, n_zero;
    logic       r_cont, n_cont;
    logic       w_push;

    assign w_push = i_sts.func == FUNC_PUSH;

    always_comb begin
        n_state    = r_state;
        n_prep     = r_prep;
        n_status   = r_status;
        n_zero     = r_zero;
        n_cont     = r_cont;
        o_cmd.op     = OP_NOP;
        o_cmd.status = r_status;
        o_cmd.zero   = r_zero;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.op = OP_CLEAR;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_prep   = '0;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                n_prep = r_prep + 1'b1;
                if (r_prep == 2'd2) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status = ST_OK;
                n_zero   = 1'b0;
                n_cont   = 1'b0;
                n_state  = S_IDLE;
                case (i_sts.func)
                    FUNC_LOAD: begin
                        o_cmd.op = OP_LOAD;
                    end
                    FUNC_PUSH: begin
                        if (i_sts.frames_full) begin
                            n_status = ST_TOO_MANY;
                            n_state  = S_EMIT;
                        end else begin
                            n_cont  = 1'b1;
                            n_state = i_sts.fin_due ? S_FIN_DIV : S_ADD_DIV;
                        end
                    end
                    FUNC_FLUSH: begin
                        if (i_sts.frame_open) begin
                            n_status = ST_EARLY;
                            n_state  = S_EMIT;
                        end else if (i_sts.out_done) begin
                            n_status = ST_DONE;
                            n_state  = S_EMIT;
                        end else if (i_sts.tail_left) begin
                            n_state = S_FIN_DIV;
                        end else begin
                            n_zero  = 1'b1;
                            n_state = S_EMIT;
                        end
                    end
                    default: ;
                endcase
            end
            S_FIN_DIV: begin
                o_cmd.op = OP_MOD_FIN;
                n_state  = S_FIN_WAIT;
            end
            S_FIN_WAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = S_FIN_RD;
                end
            end
            S_FIN_RD: begin
                o_cmd.op = OP_RING_RD;
                n_state  = S_FIN_LATCH;
            end
            S_FIN_LATCH: begin
                o_cmd.op = OP_FIN_LATCH;
                n_state  = S_FIN_NORM;
            end
            S_FIN_NORM: begin
                if (i_sts.below_eps) begin
                    o_cmd.op = OP_BYPASS;
                    n_state  = S_FIN_END;
                end else begin
                    o_cmd.op = OP_NORM_START;
                    n_state  = S_NORM_WAIT;
                end
            end
            S_NORM_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = OP_NORM_DONE;
                    n_state  = S_FIN_END;
                end
            end
            S_FIN_END: begin
                n_cont = w_push;
                if (i_sts.in_window) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = w_push ? S_ADD_DIV : S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = r_cont ? S_ADD_DIV : S_IDLE;
                end
            end
            S_ADD_DIV: begin
                o_cmd.op = OP_MOD_ADD;
                n_state  = S_ADD_WAIT;
            end
            S_ADD_WAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = S_ADD_RD;
                end
            end
            S_ADD_RD: begin
                o_cmd.op = OP_RING_RD;
                n_state  = S_ADD_WR;
            end
            S_ADD_WR: begin
                o_cmd.op = OP_ADD_WRITE;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_prep   <= '0;
            r_status <= ST_OK;
            r_zero   <= 1'b0;
            r_cont   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_prep   <= n_prep;
            r_status <= n_status;
            r_zero   <= n_zero;
            r_cont   <= n_cont;
        end
    end

    assign o_ready = r_state == S_IDLE;

endmodule

// ===== hw/rtl/istft_overlap_add_normalizer.sv =====
// The shared bit-serial divider runs 32 steps per ring modulo and 64 steps per window-sum
// normalization; a push runs one or two modulo passes and at most one division.
// One word is worked on at a time; a stalled output register holds the word in the emit state.
// After reset all 4096 ring entries are cleared, one entry per cycle, before any word is
// taken; configuration writes are taken during that pass.
// ----------------------------------------------------------------------------
// istft_overlap_add_normalizer
// Inverse-STFT overlap-add with window-sum normalization and center trim.
// ----------------------------------------------------------------------------
module istft_overlap_add_normalizer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [istft_ola_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [istft_ola_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  istft_ola_pkg::t_in_item              i_in,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output istft_ola_pkg::t_out_item             o_out
);
    import istft_ola_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    ctrl_ready;

    istft_ola_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd),
        .o_ready (ctrl_ready)
    );

    istft_ola_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (dp_cmd),
        .i_stall     (i_stall),
        .o_sts       (dp_sts),
        .o_valid     (o_valid),
        .o_out       (o_out)
    );

    assign o_stall = !ctrl_ready;

endmodule
